>>> hw/rtl/sparse_disk_cluster_mapper_assert.svh
// Assertion macros for the sparse disk cluster mapper.
`ifndef SPARSE_DISK_CLUSTER_MAPPER_ASSERT_SVH
`define SPARSE_DISK_CLUSTER_MAPPER_ASSERT_SVH

// Same-cycle implication.
`define SDCM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SDCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/sdcm_pkg.sv
// Shared constants and controller/datapath interface types.
`default_nettype none
package sdcm_pkg;

  localparam int unsigned DEF_MAX_CLUSTERS = 1024;
  localparam int unsigned DEF_MAX_BLOCKS   = 65536;
  localparam int unsigned BLOCK_SHIFT      = 9;
  localparam int unsigned OFS_W            = 40;
  localparam int unsigned USED_OUT_W       = 11;

  localparam logic [4:0]  CB_MIN = 5'd9;
  localparam logic [4:0]  CB_MAX = 5'd24;

  localparam logic [4:0]  RST_CLUSTER_BITS = 5'd16;
  localparam logic [31:0] RST_DATA_START   = 32'd1048576;
  localparam logic [16:0] RST_DISK_BLOCKS  = 17'd65536;

  localparam logic [1:0] CFG_CLUSTER_BITS = 2'd0;
  localparam logic [1:0] CFG_DATA_START   = 2'd1;
  localparam logic [1:0] CFG_DISK_BLOCKS  = 2'd2;

  localparam logic [2:0] KIND_READ     = 3'd0;
  localparam logic [2:0] KIND_ZERO     = 3'd1;
  localparam logic [2:0] KIND_WRITE    = 3'd2;
  localparam logic [2:0] KIND_DROPPED  = 3'd3;
  localparam logic [2:0] KIND_MOVE     = 3'd4;
  localparam logic [2:0] KIND_TRUNC    = 3'd5;
  localparam logic [2:0] KIND_RANGE    = 3'd6;
  localparam logic [2:0] KIND_BAD      = 3'd7;

  typedef struct packed {
    logic clr;
    logic accept;
    logic look;
    logic scan;
    logic move;
    logic bad;
    logic trunc;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
    logic need_free;
    logic scan_done;
    logic chk_ok;
    logic hi_is_cl;
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/sdcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sdcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/sdcm_ctrl.sv
// Access sequencer: clearing pass, lookup, free scan, check and truncate.
`default_nettype none
module sdcm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire sdcm_pkg::sts_t sts_i,
  output sdcm_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_CHECK,
    ST_TRUNC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.clr = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (sts_i.out_free) begin
          cmd_o.look = 1'b1;
          state_d    = sts_i.need_free ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.out_free) begin
          if (!sts_i.chk_ok) begin
            cmd_o.bad = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            cmd_o.move = !sts_i.hi_is_cl;
            state_d    = ST_TRUNC;
          end
        end
      end
      ST_TRUNC: begin
        if (sts_i.out_free) begin
          cmd_o.trunc = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

>>> hw/rtl/sdcm_dp.sv
// Datapath: config registers, map/flag/tally memories, scan and result register.
`default_nettype none
module sdcm_dp #(
  parameter int unsigned MAX_CLUSTERS = sdcm_pkg::DEF_MAX_CLUSTERS,
  parameter int unsigned MAX_BLOCKS   = sdcm_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i,
  input  wire logic           operation_i,
  input  wire logic [15:0]    block_number_i,
  input  wire logic           data_nonzero_i,
  input  wire sdcm_pkg::cmd_t cmd_i,
  output sdcm_pkg::sts_t      sts_o,
  input  wire logic           out_stall_i,
  output logic                out_valid_o,
  output logic [2:0]          kind_o,
  output logic [39:0]         file_offset_o,
  output logic [39:0]         source_offset_o,
  output logic [10:0]         used_count_o,
  output logic                last_o
);

  localparam int unsigned OW    = sdcm_pkg::OFS_W;
  localparam int unsigned MW    = OW + 1;
  localparam int unsigned CW    = $clog2(MAX_CLUSTERS);
  localparam int unsigned BW    = $clog2(MAX_BLOCKS);
  localparam int unsigned UW    = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned CLR_N = (MAX_BLOCKS > MAX_CLUSTERS) ? MAX_BLOCKS : MAX_CLUSTERS;
  localparam int unsigned KW    = $clog2(CLR_N + 1);

  // config
  logic [4:0]  cb_q;
  logic [31:0] ds_q;
  logic [16:0] db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q <= sdcm_pkg::RST_CLUSTER_BITS;
      ds_q <= sdcm_pkg::RST_DATA_START;
      db_q <= sdcm_pkg::RST_DISK_BLOCKS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdcm_pkg::CFG_CLUSTER_BITS: cb_q <= cfg_data_i[4:0];
        sdcm_pkg::CFG_DATA_START:   ds_q <= cfg_data_i;
        sdcm_pkg::CFG_DISK_BLOCKS:  db_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  logic [4:0]  cb;
  logic [3:0]  sh;
  logic [15:0] cl16;
  logic [31:0] blk32, cl32;
  logic [24:0] inner_n;
  logic        range_n;

  always_comb begin
    if (cb_q < sdcm_pkg::CB_MIN) cb = sdcm_pkg::CB_MIN;
    else if (cb_q > sdcm_pkg::CB_MAX) cb = sdcm_pkg::CB_MAX;
    else cb = cb_q;
    sh      = 4'(cb - sdcm_pkg::CB_MIN);
    cl16    = block_number_i >> sh;
    blk32   = 32'(block_number_i);
    cl32    = 32'(cl16);
    inner_n = {block_number_i, 9'b0} & ((25'd1 << cb) - 25'd1);
    range_n = ({1'b0, block_number_i} < db_q) && (blk32 < 32'(MAX_BLOCKS)) &&
              (cl32 < 32'(MAX_CLUSTERS));
  end

  // accepted item
  logic          op_q, nz_q, range_q;
  logic [BW-1:0] blk_q;
  logic [CW-1:0] cl_q;
  logic [24:0]   inner_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= operation_i;
      nz_q    <= data_nonzero_i;
      range_q <= range_n;
      blk_q   <= blk32[BW-1:0];
      cl_q    <= cl32[CW-1:0];
      inner_q <= inner_n;
    end
  end

  // clearing pass
  logic [KW-1:0] clr_q;
  logic          clr_blk, clr_cl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + KW'(1);
    end
  end

  assign clr_blk = cmd_i.clr && (clr_q < KW'(MAX_BLOCKS));
  assign clr_cl  = cmd_i.clr && (clr_q < KW'(MAX_CLUSTERS));

  // memories
  logic          map_we, map_re, flag_we, tally_we;
  logic [CW-1:0] map_wa, map_ra, tally_wa;
  logic [MW-1:0] map_wd, map_rd;
  logic [BW-1:0] flag_wa;
  logic [1:0]    flag_wd, flag_rd;
  logic [15:0]   tally_wd, tally_rd;

  sdcm_ram #(.WIDTH(MW), .DEPTH(MAX_CLUSTERS)) u_map (
    .clk_i(clk_i), .we_i(map_we), .waddr_i(map_wa), .wdata_i(map_wd),
    .re_i(map_re), .raddr_i(map_ra), .rdata_o(map_rd)
  );

  sdcm_ram #(.WIDTH(2), .DEPTH(MAX_BLOCKS)) u_flag (
    .clk_i(clk_i), .we_i(flag_we), .waddr_i(flag_wa), .wdata_i(flag_wd),
    .re_i(cmd_i.accept), .raddr_i(blk32[BW-1:0]), .rdata_o(flag_rd)
  );

  sdcm_ram #(.WIDTH(16), .DEPTH(MAX_CLUSTERS)) u_tally (
    .clk_i(clk_i), .we_i(tally_we), .waddr_i(tally_wa), .wdata_i(tally_wd),
    .re_i(cmd_i.accept), .raddr_i(cl32[CW-1:0]), .rdata_o(tally_rd)
  );

  // lookup / update
  logic [UW-1:0] used_q;
  logic          ld_valid, alloc, mapped, flag_chg, do_free, hit;
  logic [OW-1:0] ld_off, new_off, cur_off, inner40;
  logic [15:0]   t1, t2;
  logic [1:0]    newf;
  logic          wr_path;

  always_comb begin
    ld_valid = map_rd[OW];
    ld_off   = map_rd[OW-1:0];
    inner40  = OW'(inner_q);
    wr_path  = range_q && op_q;
    alloc    = !ld_valid && nz_q && (used_q < UW'(MAX_CLUSTERS));
    new_off  = OW'(ds_q) + (OW'(used_q) << cb);
    mapped   = ld_valid || alloc;
    cur_off  = alloc ? new_off : ld_off;
    newf     = {1'b1, nz_q};
    flag_chg = newf != flag_rd;
    t1       = (flag_chg && flag_rd[0] && tally_rd != 16'd0) ? tally_rd - 16'd1 : tally_rd;
    t2       = (flag_chg && nz_q && t1 != 16'hFFFF) ? t1 + 16'd1 : t1;
    do_free  = mapped && (t2 == 16'd0);
    hit      = flag_rd[0] && ld_valid;
  end

  // free scan
  logic [UW-1:0] scan_q;
  logic          pend_q, any_q, issuing;
  logic [CW-1:0] pend_idx_q, best_idx_q;
  logic [OW-1:0] best_q, exp_q, keep_off_q;

  assign issuing = cmd_i.scan && (scan_q < UW'(MAX_CLUSTERS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      scan_q     <= '0;
      pend_q     <= 1'b0;
      any_q      <= 1'b0;
      keep_off_q <= cur_off;
    end else if (cmd_i.scan) begin
      pend_q     <= issuing;
      pend_idx_q <= scan_q[CW-1:0];
      if (issuing) scan_q <= scan_q + UW'(1);
      exp_q      <= OW'(ds_q) + (OW'(used_q - UW'(1)) << cb);
      if (pend_q && map_rd[OW] && (!any_q || map_rd[OW-1:0] > best_q)) begin
        any_q      <= 1'b1;
        best_q     <= map_rd[OW-1:0];
        best_idx_q <= pend_idx_q;
      end
    end
  end

  assign map_re = cmd_i.accept || issuing;
  assign map_ra = cmd_i.accept ? cl32[CW-1:0] : scan_q[CW-1:0];

  always_comb begin
    map_we   = 1'b0;
    map_wa   = cl_q;
    map_wd   = '0;
    if (clr_cl) begin
      map_we = 1'b1;
      map_wa = clr_q[CW-1:0];
    end else if (cmd_i.look && wr_path && alloc) begin
      map_we = 1'b1;
      map_wd = {1'b1, new_off};
    end else if (cmd_i.move) begin
      map_we = 1'b1;
      map_wa = best_idx_q;
      map_wd = {1'b1, keep_off_q};
    end else if (cmd_i.trunc) begin
      map_we = 1'b1;
    end
    flag_we  = clr_blk || (cmd_i.look && wr_path && flag_chg);
    flag_wa  = clr_blk ? clr_q[BW-1:0] : blk_q;
    flag_wd  = clr_blk ? 2'b00 : newf;
    tally_we = clr_cl || (cmd_i.look && wr_path && flag_chg);
    tally_wa = clr_cl ? clr_q[CW-1:0] : cl_q;
    tally_wd = clr_cl ? 16'd0 : t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.look && wr_path && alloc) begin
      used_q <= used_q + UW'(1);
    end else if (cmd_i.trunc) begin
      used_q <= used_q - UW'(1);
    end
  end

  // result register
  logic          emit;
  logic [2:0]    e_kind;
  logic [OW-1:0] e_fo, e_so;
  logic [UW-1:0] e_used;
  logic          e_last;

  always_comb begin
    emit   = 1'b1;
    e_kind = sdcm_pkg::KIND_RANGE;
    e_fo   = '0;
    e_so   = '0;
    e_used = used_q;
    e_last = 1'b1;
    if (cmd_i.look) begin
      if (!range_q) begin
        e_kind = sdcm_pkg::KIND_RANGE;
      end else if (!op_q) begin
        e_kind = hit ? sdcm_pkg::KIND_READ : sdcm_pkg::KIND_ZERO;
        e_fo   = hit ? ld_off + inner40 : '0;
      end else begin
        e_kind = mapped ? sdcm_pkg::KIND_WRITE : sdcm_pkg::KIND_DROPPED;
        e_fo   = mapped ? cur_off + inner40 : '0;
        e_used = used_q + UW'(alloc);
        e_last = !do_free;
      end
    end else if (cmd_i.move) begin
      e_kind = sdcm_pkg::KIND_MOVE;
      e_fo   = keep_off_q;
      e_so   = best_q;
      e_last = 1'b0;
    end else if (cmd_i.bad) begin
      e_kind = sdcm_pkg::KIND_BAD;
    end else if (cmd_i.trunc) begin
      e_kind = sdcm_pkg::KIND_TRUNC;
      e_fo   = best_q;
      e_used = used_q - UW'(1);
    end else begin
      emit = 1'b0;
    end
  end

  logic          out_valid_q, last_q;
  logic [2:0]    kind_q;
  logic [OW-1:0] fo_q, so_q;
  logic [10:0]   uo_q;
  logic [31:0]   e_used32;

  assign e_used32 = 32'(e_used);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= e_kind;
      fo_q   <= e_fo;
      so_q   <= e_so;
      uo_q   <= e_used32[10:0];
      last_q <= e_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign file_offset_o   = fo_q;
  assign source_offset_o = so_q;
  assign used_count_o    = uo_q;
  assign last_o          = last_q;

  assign sts_o.clr_done  = (clr_q == KW'(CLR_N));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.need_free = wr_path && do_free;
  assign sts_o.scan_done = !issuing && !pend_q;
  assign sts_o.chk_ok    = (used_q != '0) && any_q && (best_q == exp_q);
  assign sts_o.hi_is_cl  = (best_idx_q == cl_q);

endmodule
`default_nettype wire

>>> hw/rtl/sparse_disk_cluster_mapper.sv
// Sparse disk cluster mapper: top level tying sequencer and datapath.
// After reset the block runs a clearing pass over the flag, map and tally
// memories, max(MAX_BLOCKS, MAX_CLUSTERS) entries (65536 at defaults), and
// takes no access until it ends; config writes are taken at any time.
// A read or a write that frees nothing reads the map, flag and tally
// memories on accept, then updates them (writes only) and loads the result.
// A write that frees its cluster then scans the whole map memory, one
// entry per cycle; a passed check gives a move (unless the freed cluster
// holds the highest offset) and a truncate, a failed one a bad result.
// Results sit in an output register; out_stall_i holds only the sequencer.
`default_nettype none
module sparse_disk_cluster_mapper #(
  parameter int unsigned MAX_CLUSTERS = sdcm_pkg::DEF_MAX_CLUSTERS,
  parameter int unsigned MAX_BLOCKS   = sdcm_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [15:0] block_number_i,
  input  wire logic        data_nonzero_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [39:0]      file_offset_o,
  output logic [39:0]      source_offset_o,
  output logic [10:0]      used_count_o,
  output logic             last_o
);

`include "sparse_disk_cluster_mapper_assert.svh"

  sdcm_pkg::cmd_t cmd;
  sdcm_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  sdcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sdcm_dp #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .block_number_i  (block_number_i),
    .data_nonzero_i  (data_nonzero_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .file_offset_o   (file_offset_o),
    .source_offset_o (source_offset_o),
    .used_count_o    (used_count_o),
    .last_o          (last_o)
  );

  `SDCM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, cmd.accept, in_stall_o, "no stall after accept")
  `SDCM_ASSERT_NEXT(a_trunc_last, clk_i, rst_ni, cmd.trunc, out_valid_o && kind_o == sdcm_pkg::KIND_TRUNC && last_o, "truncate result wrong")
  `SDCM_ASSERT_NEXT(a_move_not_last, clk_i, rst_ni, cmd.move, out_valid_o && kind_o == sdcm_pkg::KIND_MOVE && !last_o, "move result wrong")

endmodule
`default_nettype wire
